FILE: rtl/tset_pkg.sv
// Shared constants, entry type, token mask helper and ring address helper for the token sequence exchange table.
package tset_pkg;

  localparam int ENTRIES     = 4;
  localparam int TOKEN_BYTES = 8;

  localparam int TOK_W = 8 * TOKEN_BYTES;
  localparam int LEN_W = 4;
  localparam int SEQ_W = 40;
  localparam int HND_W = 8;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_INSERT,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [TOK_W-1:0] tok;
    logic [LEN_W-1:0] len;
    logic [SEQ_W-1:0] seq;
    logic [HND_W-1:0] hnd;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Keep only the bytes that the length covers.
  function automatic logic [TOK_W-1:0] tok_mask(input logic [LEN_W-1:0] len);
    logic [TOK_W-1:0] m;
    m = '0;
    for (int b = 0; b < TOKEN_BYTES; b++) begin
      if (32'(len) > b) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  // Ring position of an age index; both operands stay below ENTRIES.
  function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(ENTRIES)) begin
      sum = sum - (CNT_W+1)'(ENTRIES);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

FILE: rtl/token_sequence_exchange_table_top.sv
// Top level of the token sequence exchange table: ring-ordered entry RAM and its sequencer.
//
// Input channel (in_valid_i / in_stall_o) takes one operation item: lookup, insert or
// remove of a token of up to TOKEN_BYTES bytes. Output channel (out_valid_o /
// out_stall_i) returns exactly one result item per operation, in order.
// Entries sit in one RAM used as a ring (oldest at the head pointer); the RAM has
// registered read data and one read plus one write port.
// Lookup and remove scan entries oldest first, one RAM read a cycle, pipelined with
// the compare. Remove then closes the gap, moving each younger entry down one place,
// one per cycle. Insert passes through ST_INSERT and the unused code goes straight to
// ST_RESP; when the table is full the head advances, dropping the oldest entry.
// One item is worked on at a time; in_stall_o is high from acceptance until the
// result is handed to the output register, which may still hold the previous
// result while the next item is accepted.
// Reset empties the table (count and head to zero); RAM contents need no clearing.
// A stalled receiver holds the result in the output register; a finished item then
// waits for it to drain before the next one is taken.
module token_sequence_exchange_table_top
  import tset_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [1:0]   op_i,
  input  logic [63:0]  token_i,
  input  logic [3:0]   token_length_i,
  input  logic [39:0]  sequence_req_i,
  input  logic [7:0]   handle_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic         hit_o,
  output logic [39:0]  sequence_out_o,
  output logic [7:0]   handle_out_o,
  output logic         evicted_o
);

  state_e state_q, state_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] pend_idx_q, pend_idx_d;
  logic [CNT_W-1:0] wr_idx_q, wr_idx_d;
  logic             pend_q, pend_d;

  logic [1:0]       op_q;
  entry_t           req_q;

  logic             res_hit_q, res_hit_d;
  logic [SEQ_W-1:0] res_seq_q, res_seq_d;
  logic [HND_W-1:0] res_hnd_q, res_hnd_d;
  logic             res_evict_q, res_evict_d;

  logic             out_valid_q, out_valid_d;
  logic             out_hit_q;
  logic [SEQ_W-1:0] out_seq_q;
  logic [HND_W-1:0] out_hnd_q;
  logic             out_evict_q;
  logic             out_load;

  logic             accept;
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;
  logic             match;
  logic             issue;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  tset_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign match = pend_q && (ram_rdata.len == req_q.len) && (ram_rdata.tok == req_q.tok);
  assign issue = (idx_q < count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      pend_idx_q  <= '0;
      wr_idx_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      pend_idx_q  <= pend_idx_d;
      wr_idx_q    <= wr_idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload, result and output registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_i;
      req_q.tok <= token_i[TOK_W-1:0] & tok_mask(token_length_i);
      req_q.len <= token_length_i;
      req_q.seq <= sequence_req_i;
      req_q.hnd <= handle_i;
    end
    res_hit_q   <= res_hit_d;
    res_seq_q   <= res_seq_d;
    res_hnd_q   <= res_hnd_d;
    res_evict_q <= res_evict_d;
    if (out_load) begin
      out_hit_q   <= res_hit_q;
      out_seq_q   <= res_seq_q;
      out_hnd_q   <= res_hnd_q;
      out_evict_q <= res_evict_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pend_idx_d  = pend_idx_q;
    wr_idx_d    = wr_idx_q;
    pend_d      = pend_q;
    res_hit_d   = res_hit_q;
    res_seq_d   = res_seq_q;
    res_hnd_d   = res_hnd_q;
    res_evict_d = res_evict_q;
    ram_we      = 1'b0;
    ram_waddr   = phys_addr(head_q, wr_idx_q);
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = phys_addr(head_q, idx_q);
    out_load    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_hit_d   = 1'b0;
          res_seq_d   = '0;
          res_hnd_d   = '0;
          res_evict_d = 1'b0;
          idx_d       = '0;
          pend_d      = 1'b0;
          case (op_i)
            OP_LOOKUP, OP_REMOVE: state_d = ST_SCAN;
            OP_INSERT:            state_d = ST_INSERT;
            default:              state_d = ST_RESP;
          endcase
        end
      end

      ST_SCAN: begin
        if (match) begin
          res_hit_d = 1'b1;
          pend_d    = 1'b0;
          if (op_q == OP_LOOKUP) begin
            res_seq_d = ram_rdata.seq;
            res_hnd_d = ram_rdata.hnd;
            state_d   = ST_RESP;
          end else begin
            // Close the gap from the entry just younger than the match
            idx_d   = pend_idx_q + CNT_W'(1);
            state_d = ST_SHIFT;
          end
        end else if (issue) begin
          ram_re     = 1'b1;
          idx_d      = idx_q + CNT_W'(1);
          pend_idx_d = idx_q;
          pend_d     = 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = ST_RESP;
        end
      end

      ST_SHIFT: begin
        if (pend_q) begin
          ram_we = 1'b1;
        end
        if (issue) begin
          ram_re   = 1'b1;
          idx_d    = idx_q + CNT_W'(1);
          wr_idx_d = idx_q - CNT_W'(1);
          pend_d   = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            count_d = count_q - CNT_W'(1);
            state_d = ST_RESP;
          end
        end
      end

      ST_INSERT: begin
        ram_we    = 1'b1;
        ram_wdata = req_q;
        if (count_q == CNT_W'(ENTRIES)) begin
          // Full: the oldest slot takes the new entry and the head moves on
          ram_waddr   = head_q;
          head_d      = phys_addr(head_q, CNT_W'(1));
          res_evict_d = 1'b1;
        end else begin
          ram_waddr = phys_addr(head_q, count_q);
          count_d   = count_q + CNT_W'(1);
        end
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = out_hit_q;
  assign sequence_out_o = out_seq_q;
  assign handle_out_o   = out_hnd_q;
  assign evicted_o      = out_evict_q;

endmodule

FILE: rtl/tset_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tset_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: tb/tset_reply_checker.sv
// Checker for the token sequence exchange table: mirrors the table and compares every result item.
`timescale 1ns / 1ps
module tset_reply_checker
  import tset_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [1:0]       op_i,
  input  logic [TOK_W-1:0] token_i,
  input  logic [LEN_W-1:0] token_length_i,
  input  logic [SEQ_W-1:0] sequence_req_i,
  input  logic [HND_W-1:0] handle_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic             hit_i,
  input  logic [SEQ_W-1:0] sequence_out_i,
  input  logic [HND_W-1:0] handle_out_i,
  input  logic             evicted_i,
  output int               mismatch_cnt_o,
  output int               pending_cnt_o,
  output int               reply_cnt_o,
  output int               hit_cnt_o,
  output int               evict_cnt_o
);

  typedef struct packed {
    logic             hit;
    logic [SEQ_W-1:0] seq;
    logic [HND_W-1:0] hnd;
    logic             evicted;
  } reply_t;

  // Mirror of the table, oldest row first.
  logic [TOK_W-1:0] row_tok [ENTRIES];
  logic [LEN_W-1:0] row_len [ENTRIES];
  logic [SEQ_W-1:0] row_seq [ENTRIES];
  logic [HND_W-1:0] row_hnd [ENTRIES];
  int               rows = 0;

  reply_t awaited_replies[$];
  int     mismatches = 0;
  int     replies    = 0;
  int     hits       = 0;
  int     evicts     = 0;

  function automatic logic [TOK_W-1:0] covered_bytes(input logic [LEN_W-1:0] len);
    int n;
    n = (int'(len) < TOKEN_BYTES) ? int'(len) : TOKEN_BYTES;
    covered_bytes = '0;
    for (int b = 0; b < n; b++) begin
      covered_bytes[8*b +: 8] = 8'hFF;
    end
  endfunction

  function automatic int oldest_row(input logic [TOK_W-1:0] tok, input logic [LEN_W-1:0] len);
    for (int i = 0; i < rows; i++) begin
      if (row_len[i] == len && row_tok[i] == tok) begin
        return i;
      end
    end
    return rows;
  endfunction

  // Shift younger rows down over the dropped one.
  task automatic close_gap(input int idx);
    for (int i = idx; i < rows - 1; i++) begin
      row_tok[i] = row_tok[i+1];
      row_len[i] = row_len[i+1];
      row_seq[i] = row_seq[i+1];
      row_hnd[i] = row_hnd[i+1];
    end
    if (rows > 0) begin
      rows--;
    end
  endtask

  task automatic apply_table_op(input logic [1:0] op, input logic [TOK_W-1:0] tok,
                                input logic [LEN_W-1:0] len, input logic [SEQ_W-1:0] seq,
                                input logic [HND_W-1:0] hnd, output reply_t r);
    logic [TOK_W-1:0] key;
    int               idx;
    key = tok & covered_bytes(len);
    r   = '0;
    case (op)
      OP_LOOKUP: begin
        idx = oldest_row(key, len);
        if (idx < rows) begin
          r.hit = 1'b1;
          r.seq = row_seq[idx];
          r.hnd = row_hnd[idx];
        end
      end
      OP_INSERT: begin
        if (rows >= ENTRIES) begin
          close_gap(0);
          r.evicted = 1'b1;
        end
        row_tok[rows] = key;
        row_len[rows] = len;
        row_seq[rows] = seq;
        row_hnd[rows] = hnd;
        rows++;
      end
      OP_REMOVE: begin
        idx = oldest_row(key, len);
        if (idx < rows) begin
          r.hit = 1'b1;
          close_gap(idx);
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    reply_t got;
    reply_t want;
    if (!rst_ni) begin
      rows = 0;
      awaited_replies.delete();
    end else begin
      // Retire first: a result seen this edge belongs to an earlier item.
      if (out_valid_i && !out_stall_i) begin
        got = {hit_i, sequence_out_i, handle_out_i, evicted_i};
        replies++;
        if (awaited_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result item %0d with nothing outstanding: hit=%0b seq=%h hnd=%h ev=%0b",
                     $realtime, replies, got.hit, got.seq, got.hnd, got.evicted);
          end
        end else begin
          want = awaited_replies.pop_front();
          if (want.hit) hits++;
          if (want.evicted) evicts++;
          if (got.hit !== want.hit || got.seq !== want.seq || got.hnd !== want.hnd ||
              got.evicted !== want.evicted) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result item %0d: expected hit=%0b seq=%h hnd=%h ev=%0b", $realtime,
                       replies, want.hit, want.seq, want.hnd, want.evicted);
              $display("%0t: result item %0d: actual   hit=%0b seq=%h hnd=%h ev=%0b", $realtime,
                       replies, got.hit, got.seq, got.hnd, got.evicted);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        apply_table_op(op_i, token_i, token_length_i, sequence_req_i, handle_i, want);
        awaited_replies.push_back(want);
      end
    end
    mismatch_cnt_o <= mismatches;
    pending_cnt_o  <= awaited_replies.size();
    reply_cnt_o    <= replies;
    hit_cnt_o      <= hits;
    evict_cnt_o    <= evicts;
  end

endmodule

FILE: tb/token_sequence_exchange_table_top_tb.sv
// Testbench top for the token sequence exchange table: reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module token_sequence_exchange_table_top_tb;
  import tset_pkg::*;

  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1180;
  localparam int QUIET_ITEMS  = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int POOL         = 6;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic [1:0]       drv_op    = OP_LOOKUP;
  logic [TOK_W-1:0] drv_token = '0;
  logic [LEN_W-1:0] drv_len   = '0;
  logic [SEQ_W-1:0] drv_seq   = '0;
  logic [HND_W-1:0] drv_hnd   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             hit;
  logic [SEQ_W-1:0] seq_out;
  logic [HND_W-1:0] hnd_out;
  logic             evicted;

  int mismatches, pending, replies, hits, evicts;

  int op_tally[4];
  int gap_pct     = 0;
  bit quiet       = 1'b0;
  int hold_asked  = 0;
  int hold_done   = 0;

  logic [TOK_W-1:0] pool_tok [POOL];
  logic [LEN_W-1:0] pool_len [POOL];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  token_sequence_exchange_table_top u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .op_i          (drv_op),
    .token_i       (drv_token),
    .token_length_i(drv_len),
    .sequence_req_i(drv_seq),
    .handle_i      (drv_hnd),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .hit_o         (hit),
    .sequence_out_o(seq_out),
    .handle_out_o  (hnd_out),
    .evicted_o     (evicted)
  );

  tset_reply_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .op_i          (drv_op),
    .token_i       (drv_token),
    .token_length_i(drv_len),
    .sequence_req_i(drv_seq),
    .handle_i      (drv_hnd),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .hit_i         (hit),
    .sequence_out_i(seq_out),
    .handle_out_i  (hnd_out),
    .evicted_i     (evicted),
    .mismatch_cnt_o(mismatches),
    .pending_cnt_o (pending),
    .reply_cnt_o   (replies),
    .hit_cnt_o     (hits),
    .evict_cnt_o   (evicts)
  );

  function automatic logic [TOK_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [SEQ_W-1:0] rand_seq();
    return SEQ_W'({$urandom, $urandom});
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [TOK_W-1:0] tok,
                           input logic [LEN_W-1:0] len, input logic [SEQ_W-1:0] seq,
                           input logic [HND_W-1:0] hnd);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 15);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    drv_op    = op;
    drv_token = tok;
    drv_len   = len;
    drv_seq   = seq;
    drv_hnd   = hnd;
    in_valid  = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    op_tally[op]++;
  endtask

  // Hold the sender until every outstanding result has come back.
  task automatic drain_pause();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic refill_pool();
    for (int i = 0; i < POOL; i++) begin
      pool_tok[i] = rand_word();
      pool_len[i] = ($urandom_range(0, 99) < 5) ? LEN_W'($urandom_range(9, 15))
                                                : LEN_W'($urandom_range(0, 8));
    end
  endtask

  // Mostly reuse pooled tokens so that lookups and removes find matches.
  task automatic send_random();
    int               pick;
    int               slot;
    logic [1:0]       op;
    logic [TOK_W-1:0] tok;
    logic [TOK_W-1:0] keep;
    logic [LEN_W-1:0] len;
    pick = $urandom_range(0, 99);
    op = (pick < 40) ? OP_LOOKUP : (pick < 74) ? OP_INSERT : (pick < 97) ? OP_REMOVE : OP_NOP;
    if ($urandom_range(0, 9) < 8) begin
      slot = $urandom_range(0, POOL - 1);
      len  = pool_len[slot];
      keep = (len >= 8) ? '1 : (64'd1 << (8 * len)) - 64'd1;
      // scramble the bytes beyond the length, which must not matter
      tok  = (pool_tok[slot] & keep) | (rand_word() & ~keep);
    end else begin
      len = LEN_W'($urandom_range(0, 8));
      tok = rand_word();
    end
    send_item(op, tok, len, rand_seq(), HND_W'($urandom));
  endtask

  // Receiver: random stall bursts, one long hold-off on request, none in the quiet tail.
  initial begin
    int burst;
    forever begin
      @(negedge clk);
      if (hold_done < hold_asked) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done++;
      end else if (quiet || $urandom_range(0, 99) >= 20) begin
        out_stall = 1'b0;
        if (!quiet) repeat ($urandom_range(0, 12)) @(negedge clk);
      end else begin
        out_stall = 1'b1;
        burst = $urandom_range(1, 15);
        repeat (burst - 1) @(negedge clk);
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped at the cycle limit of %0d with %0d results outstanding",
             CYCLE_LIMIT, pending);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty table: lookup and remove both miss.
    send_item(OP_LOOKUP, '1, 4'd8, '1, '1);
    send_item(OP_REMOVE, '0, 4'd0, '0, '0);
    // Zero-length token: every byte ignored.
    send_item(OP_INSERT, '1, 4'd0, '1, 8'hFF);
    send_item(OP_LOOKUP, '0, 4'd0, '0, '0);
    send_item(OP_INSERT, '1, 4'd8, '0, 8'h00);
    send_item(OP_INSERT, 64'hA5A5_A5A5_A512_3456, 4'd3, 40'h1, 8'h11);
    send_item(OP_LOOKUP, 64'h0000_0000_0012_3456, 4'd3, '1, '1);
    send_item(OP_LOOKUP, 64'h0000_0000_0012_3457, 4'd3, '0, '0);
    send_item(OP_LOOKUP, 64'h0000_0000_0012_3456, 4'd4, '0, '0);
    // Duplicate fills the table; lookup must return the older copy.
    send_item(OP_INSERT, 64'hFFFF_0000_0012_3456, 4'd3, 40'h2, 8'h22);
    send_item(OP_LOOKUP, 64'h0000_0000_0012_3456, 4'd3, '0, '0);
    // Full table: insert drops the oldest. Length above the token size is kept whole.
    send_item(OP_INSERT, 64'h0123_4567_89AB_CDEF, 4'd12, 40'hAB_CDEF_0123, 8'h5A);
    send_item(OP_LOOKUP, 64'h0123_4567_89AB_CDEF, 4'd12, '0, '0);
    send_item(OP_LOOKUP, 64'h0123_4567_89AB_CDEF, 4'd8, '0, '0);
    // Remove from the middle closes the gap.
    send_item(OP_REMOVE, 64'h0000_0000_0012_3456, 4'd3, '0, '0);
    send_item(OP_LOOKUP, 64'h0000_0000_0012_3456, 4'd3, '0, '0);
    send_item(OP_REMOVE, 64'h0000_00AB_CDEF_0011, 4'd5, '0, '0);
    send_item(OP_NOP, '1, 4'hF, '1, '1);
    send_item(OP_REMOVE, '1, 4'd8, '0, '0);
    send_item(OP_LOOKUP, '0, 4'd0, '0, '0);
    send_item(OP_INSERT, '0, 4'd1, '1, 8'hA5);
    send_item(OP_LOOKUP, '0, 4'd8, '0, '0);
    send_item(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00, 4'd1, '0, '0);
    drain_pause();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) begin
        refill_pool();
        case ($urandom_range(0, 3))
          0:       gap_pct = 0;
          1:       gap_pct = 10;
          2:       gap_pct = 25;
          default: gap_pct = 40;
        endcase
      end
      if (i == 300) hold_asked++;
      if (i == 650) drain_pause();
      if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      send_random();
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Items driven: %0d lookups, %0d inserts, %0d removes, %0d with the unused code",
             op_tally[OP_LOOKUP], op_tally[OP_INSERT], op_tally[OP_REMOVE], op_tally[OP_NOP]);
    $display("Results checked: %0d, %0d matches found, %0d evictions, %0d mismatches",
             replies, hits, evicts, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
